### src/lf_pkg.sv
// shared types and constants for the line folder
`timescale 1ns / 1ps
`default_nettype none

package lf_pkg;

   localparam int unsigned ByteW  = 8;
   localparam int unsigned WidthW = 6;

   localparam logic [ByteW-1:0] ChNewline = 8'd10;
   localparam logic [ByteW-1:0] ChBlank   = 8'd32;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAIN,
      ST_NEWLINE
   } lf_state_type;

   // per-cell control
   typedef struct packed {
      logic shift;
      logic load;
   } lf_cell_ctl_type;

endpackage

`default_nettype wire

### src/line_folder_core.sv
// line folder top level: control, config register and cell chain
`timescale 1ns / 1ps
`default_nettype none

// line_folder_core wraps a text byte stream into lines of at most column_width
// characters, breaking after the last blank where there is one.
// channels:
//   req_*  one input character per transaction (valid/ready)
//   rsp_*  output characters, rsp_last_of_run marks the final byte of the
//          run caused by one input character
//   csr_*  write-only column width register, always ready, write only while idle
// timing:
//   a plain character that fits is stored in its accept cycle, no output
//   a newline or a folding character is accepted, then the held bytes to
//   the break are emitted, then the newline; bytes leave the head of the
//   cell chain one per cycle while the output is not stalled, the chain
//   shifting as they go, so the burst length sets the input rate
//   a new character is accepted only when the previous run is fully queued
// reset: synchronous, clears the held line and sets the width to 63
// stall: while rsp_ready is low the output register holds and the chain
//   stops shifting; nothing is lost or repeated

module line_folder_core #(
   parameter int unsigned MAX_COLUMNS = 63
) (
   input  wire                        clock,
   input  wire                        reset,
   // input characters
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire [lf_pkg::ByteW-1:0]    req_in_byte,
   // output characters
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic [lf_pkg::ByteW-1:0]   rsp_out_byte,
   output logic                       rsp_last_of_run,
   // config register
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire [lf_pkg::WidthW-1:0]   csr_column_width
);
   import lf_pkg::*;

   localparam int unsigned CntW = $clog2(MAX_COLUMNS + 1);
   localparam int unsigned PosW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   // state and registers
   lf_state_type      state_ff, state_in;
   logic [CntW-1:0]   held_ff, held_in;
   logic [CntW-1:0]   remaining_ff, remaining_in;
   logic [CntW-1:0]   last_blank_ff, last_blank_in;
   logic              blank_seen_ff, blank_seen_in;
   logic [ByteW-1:0]  char_ff, char_in;
   logic              char_nl_ff, char_nl_in;
   logic [WidthW-1:0] width_ff, width_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ByteW-1:0]  rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;

   // decode
   logic [WidthW-1:0] eff_width;
   logic              in_nl;
   logic              in_fold;
   logic [CntW-1:0]   cut;
   logic              accept;
   logic              out_free;
   logic              emit_en;
   logic              shift_en;
   logic              append_en;
   logic [ByteW-1:0]  append_byte;

   // cell chain
   logic [ByteW-1:0]  chain_byte [MAX_COLUMNS];

   // effective width: zero acts as one, capped at the store depth
   always_comb begin
      eff_width = width_ff;
      if (width_ff == '0) begin
         eff_width = WidthW'(1);
      end
      if (eff_width > WidthW'(MAX_COLUMNS)) begin
         eff_width = WidthW'(MAX_COLUMNS);
      end
   end

   assign in_nl   = (req_in_byte == ChNewline);
   assign in_fold = (WidthW'(held_ff) >= eff_width);

   // break after the last blank, or take the whole line
   assign cut = (blank_seen_ff && (last_blank_ff < held_ff))
                ? (last_blank_ff + CntW'(1)) : held_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (in_nl) begin
                  state_in = (held_ff == '0) ? ST_NEWLINE : ST_DRAIN;
               end else if (in_fold) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (out_free && (remaining_ff == CntW'(1))) begin
               state_in = ST_NEWLINE;
            end
         end
         ST_NEWLINE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      emit_en     = 1'b0;
      shift_en    = 1'b0;
      append_en   = 1'b0;
      append_byte = req_in_byte;
      unique case (state_ff)
         ST_IDLE: begin
            append_en = accept && !in_nl && !in_fold;
         end
         ST_DRAIN: begin
            emit_en  = out_free;
            shift_en = out_free;
         end
         ST_NEWLINE: begin
            emit_en     = out_free;
            append_en   = out_free && !char_nl_ff;
            append_byte = char_ff;
         end
         default: ;
      endcase
   end

   // line bookkeeping
   always_comb begin
      held_in       = held_ff;
      remaining_in  = remaining_ff;
      last_blank_in = last_blank_ff;
      blank_seen_in = blank_seen_ff;
      char_in       = char_ff;
      char_nl_in    = char_nl_ff;
      width_in      = width_ff;

      if (csr_valid) begin
         width_in = csr_column_width;
      end

      if (accept) begin
         char_in      = req_in_byte;
         char_nl_in   = in_nl;
         remaining_in = in_nl ? held_ff : cut;
      end

      if (shift_en) begin
         held_in      = held_ff - CntW'(1);
         remaining_in = remaining_ff - CntW'(1);
      end

      // line end or fold forgets the blank position
      if ((state_ff == ST_NEWLINE) && out_free) begin
         blank_seen_in = 1'b0;
         last_blank_in = '0;
         held_in       = '0;
      end

      if (append_en) begin
         held_in = held_ff + CntW'(1);
         if (append_byte == ChBlank) begin
            blank_seen_in = 1'b1;
            last_blank_in = held_ff;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit_en) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = (state_ff == ST_DRAIN) ? chain_byte[0] : ChNewline;
         rsp_last_in  = (state_ff == ST_NEWLINE);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_ff       <= '0;
         remaining_ff  <= '0;
         last_blank_ff <= '0;
         blank_seen_ff <= 1'b0;
         width_ff      <= WidthW'(63);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_ff       <= held_in;
         remaining_ff  <= remaining_in;
         last_blank_ff <= last_blank_in;
         blank_seen_ff <= blank_seen_in;
         width_ff      <= width_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      char_nl_ff  <= char_nl_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last_of_run = rsp_last_ff;

   // cell chain: cell 0 is the head of the line, each shift moves every
   // byte one place toward the head; a cell loads when the append pointer
   // names it
   for (genvar i = 0; i < MAX_COLUMNS; i++) begin : g_cell
      lf_cell_ctl_type   ctl;
      logic [ByteW-1:0]  next_byte;

      assign ctl.shift = shift_en;
      assign ctl.load  = append_en && (held_ff == CntW'(i));

      if (i == MAX_COLUMNS - 1) begin : g_tail
         assign next_byte = '0;
      end else begin : g_link
         assign next_byte = chain_byte[PosW'(i + 1)];
      end

      lf_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load_byte (append_byte),
         .next_byte (next_byte),
         .cell_byte (chain_byte[i])
      );
   end

endmodule

`default_nettype wire

### src/lf_cell.sv
// one character cell of the held-line shift chain
`timescale 1ns / 1ps
`default_nettype none

module lf_cell (
   input  wire                       clock,
   input  wire lf_pkg::lf_cell_ctl_type ctl,
   input  wire [lf_pkg::ByteW-1:0]   load_byte,
   input  wire [lf_pkg::ByteW-1:0]   next_byte,
   output logic [lf_pkg::ByteW-1:0]  cell_byte
);
   import lf_pkg::*;

   logic [ByteW-1:0] byte_ff;
   logic [ByteW-1:0] byte_in;

   // shift toward the head has priority, load never coincides with it
   always_comb begin
      byte_in = byte_ff;
      if (ctl.shift) begin
         byte_in = next_byte;
      end else if (ctl.load) begin
         byte_in = load_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;

endmodule

`default_nettype wire
